// File: hw/rtl/maze_dfs_carver_top_macros.svh
// Assertion macros for the maze carver checker.
`ifndef MAZE_DFS_CARVER_TOP_MACROS_SVH
`define MAZE_DFS_CARVER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MDC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define MDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/mdc_pkg.sv
// Package for the maze carver: types, constants, state encoding.
`timescale 1ns / 1ps
`default_nettype none
package mdc_pkg;
    localparam int MAX_SIDE = 64;
    localparam int SIDE_W = $clog2(MAX_SIDE);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = 2 * SIDE_W;
    localparam int CNT_W = ADDR_W + 1;
    localparam int DIM_W = 7;
    localparam int RAND_W = 31;
    localparam int REG_HEIGHT = 0;
    localparam int REG_WIDTH = 1;
    localparam int DIM_RESET = 16;

    typedef struct packed {
        logic              mode;
        logic [RAND_W-1:0] rand_first;
        logic [RAND_W-1:0] rand_second;
    } mdc_in_t;

    typedef struct packed {
        logic              edge_valid;
        logic [SIDE_W-1:0] from_row;
        logic [SIDE_W-1:0] from_col;
        logic [SIDE_W-1:0] to_row;
        logic [SIDE_W-1:0] to_col;
        logic              done_res;
    } mdc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_START_DIV, ST_START_MARK, ST_EMPTY,
        ST_READ_N, ST_WAIT_N, ST_PICK_DIV, ST_CARVE, ST_POP, ST_POP_WAIT, ST_OUT
    } mdc_state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load_in;
        logic clr_step;
        logic start_div;
        logic col_div;
        logic start_mark;
        logic empty_res;
        logic read_nbrs;
        logic pick_div;
        logic carve;
        logic pop;
        logic pop_load;
        logic out_load;
    } mdc_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic mode;
        logic clr_last;
        logic div_busy;
        logic stack_empty;
        logic any_nbr;
    } mdc_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/mdc_divider.sv
// Restoring divider that keeps only the remainder: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mdc_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [mdc_pkg::RAND_W-1:0] dividend,
    input  wire logic [mdc_pkg::DIM_W-1:0]  divisor,
    output logic                           busy,
    output logic [mdc_pkg::DIM_W-1:0]      remainder
);
    import mdc_pkg::*;
    localparam int BIT_W = $clog2(RAND_W + 1);

    logic [RAND_W-1:0] quo_reg, quo_next;
    logic [DIM_W:0]    rem_reg, rem_next;
    logic [DIM_W-1:0]  dvs_reg, dvs_next;
    logic [BIT_W-1:0]  bits_reg, bits_next;
    logic [DIM_W:0]    trial;

    // Shift one dividend bit in and subtract when it fits.
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        bits_next = bits_reg;
        trial = {rem_reg[DIM_W-1:0], quo_reg[RAND_W-1]};
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            bits_next = BIT_W'(RAND_W);
        end else if (bits_reg != '0) begin
            quo_next = {quo_reg[RAND_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, dvs_reg}) ? trial - {1'b0, dvs_reg} : trial;
            bits_next = bits_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
        end else begin
            bits_reg <= bits_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = (bits_reg != '0);
    assign remainder = rem_reg[DIM_W-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/mdc_datapath.sv
// Datapath: visited map, cell stack, current cell, neighbor gather and result.
`timescale 1ns / 1ps
`default_nettype none
module mdc_datapath (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [mdc_pkg::DIM_W-1:0] cfg_wdata,
    input  wire mdc_pkg::mdc_in_t         in_item,
    input  wire mdc_pkg::mdc_cmd_t        cmd,
    output mdc_pkg::mdc_sts_t             sts,
    output mdc_pkg::mdc_out_t             out_item
);
    import mdc_pkg::*;

    logic [DIM_W-1:0]  height_reg, height_next, width_reg, width_next;
    logic [DIM_W-1:0]  h_eff, w_eff;
    mdc_in_t           in_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIDE_W-1:0] cr_reg, cr_next, cc_reg, cc_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [3:0]        nb_ok_reg;
    logic [SIDE_W-1:0] nr_reg [4];
    logic [SIDE_W-1:0] nc_reg [4];
    logic [SIDE_W-1:0] sel_r, sel_c;
    logic [2:0]        nb_cnt;
    logic [1:0]        pick_k;
    mdc_out_t          res_reg, res_next;

    logic              vis_mem [CELLS];
    logic [ADDR_W-1:0] stk_mem [CELLS];
    logic [ADDR_W-1:0] stk_rd_reg;
    logic              vis_rd_reg;
    logic              vis_we;
    logic [ADDR_W-1:0] vis_waddr, vis_raddr;
    logic              vis_wbit;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    logic [1:0]        rd_idx_reg;
    logic              div_start;
    logic [RAND_W-1:0] div_a;
    logic [DIM_W-1:0]  div_b, div_rem;
    logic [DIM_W-1:0]  row_tmp_reg;

    // Saturate dimensions to 1..MAX_SIDE.
    always_comb begin
        h_eff = (height_reg == '0) ? DIM_W'(1) :
                (height_reg > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : height_reg;
        w_eff = (width_reg == '0) ? DIM_W'(1) :
                (width_reg > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : width_reg;
    end

    // Config writes.
    always_comb begin
        height_next = height_reg;
        width_next = width_reg;
        if (cfg_we) begin
            case (cfg_index)
                1'(REG_HEIGHT): height_next = cfg_wdata;
                1'(REG_WIDTH):  width_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shared remainder unit for start row/col and neighbor choice.
    mdc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (sts.div_busy),
        .remainder(div_rem)
    );

    // Row first, then column, on a start; neighbor choice on a step.
    always_comb begin
        div_start = cmd.start_div || cmd.col_div || cmd.pick_div;
        div_a = in_reg.rand_first;
        div_b = h_eff;
        if (cmd.pick_div) begin
            div_a = in_reg.rand_first;
            div_b = {4'd0, nb_cnt};
        end else if (cmd.col_div) begin
            div_a = in_reg.rand_second;
            div_b = w_eff;
        end
    end

    always_comb begin
        nb_cnt = 3'(nb_ok_reg[0]) + 3'(nb_ok_reg[1]) + 3'(nb_ok_reg[2]) + 3'(nb_ok_reg[3]);
        pick_k = 2'd0;
        // Find the k-th valid neighbor, k = remainder.
        begin
            logic [2:0] seen;
            seen = '0;
            for (int i = 0; i < 4; i++) begin
                if (nb_ok_reg[i]) begin
                    if (seen == div_rem[2:0]) pick_k = 2'(i);
                    seen = seen + 3'd1;
                end
            end
        end
        sel_r = nr_reg[pick_k];
        sel_c = nc_reg[pick_k];
    end

    // Candidate neighbors in north, east, west, south order.
    logic [3:0]        cand_in;
    logic [SIDE_W-1:0] cand_r [4];
    logic [SIDE_W-1:0] cand_c [4];
    logic [DIM_W-1:0]  cr_x, cc_x;
    always_comb begin
        cr_x = {1'b0, cr_reg};
        cc_x = {1'b0, cc_reg};
        cand_r[0] = cr_reg - 1'b1; cand_c[0] = cc_reg;
        cand_r[1] = cr_reg;        cand_c[1] = cc_reg + 1'b1;
        cand_r[2] = cr_reg;        cand_c[2] = cc_reg - 1'b1;
        cand_r[3] = cr_reg + 1'b1; cand_c[3] = cc_reg;
        cand_in[0] = (cr_reg != '0) && (cr_x - 1'b1 < h_eff) && (cc_x < w_eff);
        cand_in[1] = (cr_x < h_eff) && (cc_x + 1'b1 < w_eff);
        cand_in[2] = (cr_x < h_eff) && (cc_reg != '0) && (cc_x - 1'b1 < w_eff);
        cand_in[3] = (cr_x + 1'b1 < h_eff) && (cc_x < w_eff);
    end

    // Visited map port selection.
    always_comb begin
        vis_we = 1'b0;
        vis_wbit = 1'b1;
        vis_waddr = {cr_next, cc_next};
        vis_raddr = {cand_r[rd_idx_reg], cand_c[rd_idx_reg]};
        if (cmd.clr_step) begin
            vis_we = 1'b1;
            vis_wbit = 1'b0;
            vis_waddr = clr_reg;
        end else if (cmd.start_mark || cmd.carve) begin
            vis_we = 1'b1;
        end
    end

    // Stack push: the start cell goes to the bottom, a carved cell on top.
    always_comb begin
        stk_we = cmd.start_mark || (cmd.carve && cnt_reg != CNT_W'(CELLS));
        stk_waddr = cmd.start_mark ? '0 : cnt_reg[ADDR_W-1:0];
    end

    // Current cell, stack count and result.
    always_comb begin
        cnt_next = cnt_reg;
        cr_next = cr_reg;
        cc_next = cc_reg;
        res_next = res_reg;
        if (cmd.start_mark) begin
            cr_next = row_tmp_reg[SIDE_W-1:0];
            cc_next = div_rem[SIDE_W-1:0];
            cnt_next = CNT_W'(1);
        end
        if (cmd.clr_step) res_next = '0;
        if (cmd.empty_res) begin
            res_next = '0;
            res_next.done_res = 1'b1;
        end
        if (cmd.carve) begin
            cr_next = sel_r;
            cc_next = sel_c;
            if (cnt_reg != CNT_W'(CELLS)) cnt_next = cnt_reg + 1'b1;
            res_next = '0;
            res_next.edge_valid = 1'b1;
            res_next.from_row = cr_reg;
            res_next.from_col = cc_reg;
            res_next.to_row = sel_r;
            res_next.to_col = sel_c;
        end
        if (cmd.pop) begin
            cnt_next = cnt_reg - 1'b1;
            res_next = '0;
            res_next.done_res = (cnt_reg == CNT_W'(1));
        end
        // Resume at the new top only if the stack still holds a cell.
        if (cmd.pop_load && cnt_reg != '0) begin
            cr_next = stk_rd_reg[ADDR_W-1:SIDE_W];
            cc_next = stk_rd_reg[SIDE_W-1:0];
        end
    end

    // Registers and memories.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= DIM_W'(DIM_RESET);
            width_reg <= DIM_W'(DIM_RESET);
            cnt_reg <= '0;
            cr_reg <= '0;
            cc_reg <= '0;
            clr_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            height_reg <= height_next;
            width_reg <= width_next;
            cnt_reg <= cnt_next;
            cr_reg <= cr_next;
            cc_reg <= cc_next;
            clr_reg <= cmd.clr_step ? clr_reg + 1'b1 : '0;
            if (cmd.read_nbrs) rd_idx_reg <= rd_idx_reg + 1'b1;
            else if (!cmd.pick_div) rd_idx_reg <= '0;
        end
        if (cmd.load_in) in_reg <= in_item;
        if (cmd.col_div) row_tmp_reg <= div_rem;
        if (vis_we) vis_mem[vis_waddr] <= vis_wbit;
        vis_rd_reg <= vis_mem[vis_raddr];
        if (stk_we) stk_mem[stk_waddr] <= {cr_next, cc_next};
        stk_rd_reg <= stk_mem[ADDR_W'(cnt_reg - CNT_W'(2))];
        res_reg <= res_next;
    end

    // Collect one neighbor's visited bit per cycle, as read in the cycle before.
    logic [1:0] cap_idx_reg;
    logic       cap_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_v_reg <= 1'b0;
            cap_idx_reg <= '0;
        end else begin
            cap_v_reg <= cmd.read_nbrs;
            cap_idx_reg <= rd_idx_reg;
        end
        if (cap_v_reg) begin
            nb_ok_reg[cap_idx_reg] <= cand_in[cap_idx_reg] && !vis_rd_reg;
            nr_reg[cap_idx_reg] <= cand_r[cap_idx_reg];
            nc_reg[cap_idx_reg] <= cand_c[cap_idx_reg];
        end
    end

    assign sts.mode = in_reg.mode;
    assign sts.clr_last = (clr_reg == '1);
    assign sts.stack_empty = (cnt_reg == '0);
    assign sts.any_nbr = (nb_ok_reg != '0);
    assign out_item = res_reg;
endmodule
`default_nettype wire

// File: hw/rtl/mdc_ctrl.sv
// Controller: sequences clear, start, neighbor gather, carve and backtrack.
`timescale 1ns / 1ps
`default_nettype none
module mdc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire mdc_pkg::mdc_sts_t sts,
    output mdc_pkg::mdc_cmd_t      cmd
);
    import mdc_pkg::*;

    mdc_state_t state_reg, state_next;
    logic [2:0] wait_reg, wait_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        wait_next = wait_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EMPTY;
            ST_EMPTY: begin
                if (!sts.mode) state_next = ST_CLEAR;
                else if (sts.stack_empty) state_next = ST_OUT;
                else begin
                    state_next = ST_READ_N;
                    wait_next = '0;
                end
            end
            ST_CLEAR: if (sts.clr_last) state_next = ST_START_DIV;
            ST_START_DIV: if (!sts.div_busy) state_next = ST_START_MARK;
            ST_START_MARK: if (!sts.div_busy) state_next = ST_OUT;
            ST_READ_N: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == 3'd3) state_next = ST_WAIT_N;
            end
            ST_WAIT_N: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == 3'd5) state_next = sts.any_nbr ? ST_PICK_DIV : ST_POP;
            end
            ST_PICK_DIV: state_next = ST_CARVE;
            ST_CARVE: if (!sts.div_busy) state_next = ST_OUT;
            ST_POP: state_next = ST_POP_WAIT;
            ST_POP_WAIT: state_next = ST_OUT;
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE: cmd.load_in = s_valid;
            ST_EMPTY: if (sts.mode && sts.stack_empty) cmd.empty_res = 1'b1;
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                cmd.start_div = sts.clr_last;
            end
            ST_START_DIV: cmd.col_div = !sts.div_busy;
            ST_START_MARK: cmd.start_mark = !sts.div_busy;
            ST_READ_N: cmd.read_nbrs = 1'b1;
            ST_PICK_DIV: cmd.pick_div = 1'b1;
            ST_CARVE: cmd.carve = !sts.div_busy;
            ST_POP: cmd.pop = 1'b1;
            ST_POP_WAIT: cmd.pop_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wait_reg <= '0;
        end else begin
            state_reg <= state_next;
            wait_reg <= wait_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/maze_dfs_carver_top.sv
// Top level of the depth-first maze carver.
// Usage:
//   s_valid/s_ready/s_item carry one command item: mode 0 starts a new maze,
//   mode 1 takes one carve or backtrack step. rand fields supply randomness.
//   m_valid/m_ready/m_item return exactly one result item per command.
//   cfg_we/cfg_index/cfg_wdata write grid height (index 0) and width (1); the user
//   must write them only while the block is idle, which the block does not enforce.
// Sequencing (one item at a time):
//   A step on an empty stack goes straight to its result. A step on a
//   nonempty stack first reads the four neighbor visited bits through one
//   memory port; a backtrack then pops the stack, a carve runs one pass
//   of the bit-serial remainder unit. A start item sweeps the 4096-entry
//   visited map one bit per cycle, then runs the remainder unit for the row
//   and again for the column.
// Reset: synchronous active-low aresetn sets 16x16 grid, empty stack,
//   current cell (0,0). The visited map is cleared by each start item.
// Stall: the result is held on m_item until m_ready; no new item is taken
//   until then.
`timescale 1ns / 1ps
`default_nettype none
module maze_dfs_carver_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire mdc_pkg::mdc_in_t          s_item,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output mdc_pkg::mdc_out_t              m_item,
    input  wire logic                      cfg_we,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [mdc_pkg::DIM_W-1:0] cfg_wdata
);
    import mdc_pkg::*;

    mdc_cmd_t cmd;
    mdc_sts_t sts;

    mdc_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    mdc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_item  (s_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (m_item)
    );
endmodule
`default_nettype wire

// File: hw/rtl/mdc_checker.sv
// Port-level checker for the maze carver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "maze_dfs_carver_top_macros.svh"
module mdc_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire mdc_pkg::mdc_out_t m_item
);
    import mdc_pkg::*;

    `MDC_ASSERT_IMPL(a_one_at_a_time, aclk, aresetn, m_valid, !s_ready)
    `MDC_ASSERT_NEXT(a_accept_blocks, aclk, aresetn, s_valid && s_ready, !s_ready)
    `MDC_ASSERT_IMPL(a_edge_not_done, aclk, aresetn, m_valid, !(m_item.edge_valid && m_item.done_res))
    `MDC_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
endmodule

bind maze_dfs_carver_top mdc_checker u_mdc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);
`default_nettype wire

// File: test/maze_dfs_carver_top_test.sv
// Testbench for the depth-first maze carver: directed and random mazes checked by a predictor.
`timescale 1ns / 1ps
module maze_dfs_carver_top_test;
    import mdc_pkg::*;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;
    localparam int   SETTLE     = 64;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    mdc_in_t  s_item = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mdc_out_t m_item;
    logic     cfg_we = 1'b0;
    logic     cfg_index = 1'b0;
    logic [DIM_W-1:0] cfg_wdata = '0;

    maze_dfs_carver_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Carver state mirror
    logic [DIM_W-1:0]  maze_height;
    logic [DIM_W-1:0]  maze_width;
    logic              visited [CELLS];
    logic [ADDR_W-1:0] path_stack [CELLS];
    int                path_depth;
    logic [SIDE_W-1:0] cur_row;
    logic [SIDE_W-1:0] cur_col;

    mdc_out_t pending_edges [$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       n_errors;
    int       n_starts;
    int       n_edges;
    int       n_done;
    int       n_steps;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("maze_dfs_carver_top_test NOT OK");
        $finish;
    end

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic logic is_open(int r, int c);
        return !visited[(r * MAX_SIDE + c) % CELLS];
    endfunction

    // Advance the mirror by one item and return the result it should produce
    function automatic mdc_out_t carve_predict(mdc_in_t it);
        mdc_out_t res;
        int h, w, cr, cc, n, k;
        int nr [4];
        int nc [4];
        res = '0;
        h = clamp_dim(maze_height);
        w = clamp_dim(maze_width);
        cr = cur_row;
        cc = cur_col;
        n = 0;
        if (it.mode == MODE_START) begin
            foreach (visited[i]) visited[i] = 1'b0;
            path_depth = 0;
            cur_row = SIDE_W'(it.rand_first % h);
            cur_col = SIDE_W'(it.rand_second % w);
            visited[cur_row * MAX_SIDE + cur_col] = 1'b1;
            path_stack[0] = {cur_row, cur_col};
            path_depth = 1;
            n_starts++;
            return res;
        end
        if (path_depth == 0) begin
            res.done_res = 1'b1;
            n_done++;
            return res;
        end
        // Gather open neighbors: north, east, west, south
        if (cr >= 1 && cr - 1 < h && cc < w && is_open(cr - 1, cc)) begin
            nr[n] = cr - 1; nc[n] = cc; n++;
        end
        if (cr < h && cc + 1 < w && is_open(cr, cc + 1)) begin
            nr[n] = cr; nc[n] = cc + 1; n++;
        end
        if (cr < h && cc >= 1 && cc - 1 < w && is_open(cr, cc - 1)) begin
            nr[n] = cr; nc[n] = cc - 1; n++;
        end
        if (cr + 1 < h && cc < w && is_open(cr + 1, cc)) begin
            nr[n] = cr + 1; nc[n] = cc; n++;
        end
        if (n > 0) begin
            k = it.rand_first % n;
            res.edge_valid = 1'b1;
            res.from_row = SIDE_W'(cr);
            res.from_col = SIDE_W'(cc);
            res.to_row = SIDE_W'(nr[k]);
            res.to_col = SIDE_W'(nc[k]);
            visited[(nr[k] * MAX_SIDE + nc[k]) % CELLS] = 1'b1;
            if (path_depth < CELLS) begin
                path_stack[path_depth] = {res.to_row, res.to_col};
                path_depth++;
            end
            cur_row = res.to_row;
            cur_col = res.to_col;
            n_edges++;
            return res;
        end
        // Dead end: backtrack
        path_depth--;
        if (path_depth > 0) begin
            {cur_row, cur_col} = path_stack[path_depth - 1];
        end else begin
            res.done_res = 1'b1;
            n_done++;
        end
        return res;
    endfunction

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each returned item against the oldest prediction
    always @(posedge aclk) begin
        mdc_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_edges.size() == 0) begin
                $error("unexpected result item %p", m_item);
                n_errors++;
            end else begin
                exp_res = pending_edges.pop_front();
                if (m_item.edge_valid !== exp_res.edge_valid) begin
                    $error("edge_valid exp %0d got %0d", exp_res.edge_valid, m_item.edge_valid);
                    n_errors++;
                end
                if (m_item.from_row !== exp_res.from_row) begin
                    $error("from_row exp %0d got %0d", exp_res.from_row, m_item.from_row);
                    n_errors++;
                end
                if (m_item.from_col !== exp_res.from_col) begin
                    $error("from_col exp %0d got %0d", exp_res.from_col, m_item.from_col);
                    n_errors++;
                end
                if (m_item.to_row !== exp_res.to_row) begin
                    $error("to_row exp %0d got %0d", exp_res.to_row, m_item.to_row);
                    n_errors++;
                end
                if (m_item.to_col !== exp_res.to_col) begin
                    $error("to_col exp %0d got %0d", exp_res.to_col, m_item.to_col);
                    n_errors++;
                end
                if (m_item.done_res !== exp_res.done_res) begin
                    $error("done_res exp %0d got %0d", exp_res.done_res, m_item.done_res);
                    n_errors++;
                end
            end
        end
    end

    // Send one item, with an optional idle gap first; valid stays up for the next call
    task automatic send_item(logic mode, logic [RAND_W-1:0] r1, logic [RAND_W-1:0] r2);
        mdc_in_t it;
        mdc_out_t exp_item;
        int gap;
        it.mode = mode;
        it.rand_first = r1;
        it.rand_second = r2;
        @(negedge aclk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        #0;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        exp_item = carve_predict(it);
        pending_edges = {pending_edges, exp_item};
        if (mode == MODE_STEP) n_steps++;
    endtask

    task automatic send_step();
        send_item(MODE_STEP, RAND_W'($urandom), RAND_W'($urandom));
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_edges.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_dim(int idx, logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx[0];
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_HEIGHT) maze_height = val;
        else maze_width = val;
    endtask

    task automatic set_grid(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w);
        drain();
        write_dim(REG_HEIGHT, h);
        write_dim(REG_WIDTH, w);
    endtask

    task automatic test_directed();
        // Step before any start sees an empty stack
        send_step();
        // Single cell grid: start, then backtrack to done, then empty step
        set_grid(7'd1, 7'd1);
        send_item(MODE_START, {RAND_W{1'b1}}, {RAND_W{1'b1}});
        send_step();
        send_step();
        // Zero dims saturate to one
        set_grid(7'd0, 7'd0);
        send_item(MODE_START, RAND_W'(5), RAND_W'(9));
        send_step();
        // Oversized dims saturate to the full side
        set_grid(7'd127, 7'd100);
        send_item(MODE_START, {RAND_W{1'b1}}, '0);
        repeat (4) send_item(MODE_STEP, {RAND_W{1'b1}}, '0);
        send_item(MODE_START, '0, {RAND_W{1'b1}});
        repeat (3) send_item(MODE_STEP, '0, {RAND_W{1'b1}});
        // Shrink mid-maze so the current cell falls outside the grid
        set_grid(7'd64, 7'd64);
        send_item(MODE_START, RAND_W'(63), RAND_W'(63));
        send_step();
        set_grid(7'd2, 7'd2);
        repeat (4) send_step();
        set_grid(7'd2, 7'd3);
        send_item(MODE_START, RAND_W'(1), RAND_W'(2));
        repeat (6) send_step();
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) return 7'd0;
        if (sel < 6) return 7'd64;
        if (sel < 8) return DIM_W'($urandom_range(65, 127));
        if (sel < 12) return DIM_W'($urandom_range(9, 63));
        return DIM_W'($urandom_range(1, 6));
    endfunction

    // Whole mazes with random content, plus some restarts and resizes mid-maze
    task automatic test_random_mazes(int step_budget);
        int stop_at;
        int budget;
        stop_at = n_steps + step_budget;
        while (n_steps < stop_at) begin
            set_grid(pick_dim(), pick_dim());
            send_item(MODE_START, RAND_W'($urandom), RAND_W'($urandom));
            budget = (clamp_dim(maze_height) * clamp_dim(maze_width) > 64) ? 40 : 200;
            while (budget > 0 && path_depth > 0) begin
                case ($urandom_range(0, 99))
                    0: send_item(MODE_START, RAND_W'($urandom), RAND_W'($urandom));
                    1: set_grid(pick_dim(), pick_dim());
                    default: send_step();
                endcase
                budget--;
            end
            if ($urandom_range(0, 3) == 0) send_step();
        end
    endtask

    initial begin
        maze_height = DIM_W'(DIM_RESET);
        maze_width = DIM_W'(DIM_RESET);
        path_depth = 0;
        cur_row = '0;
        cur_col = '0;
        foreach (visited[i]) visited[i] = 1'b0;
        n_errors = 0;
        n_starts = 0;
        n_edges = 0;
        n_done = 0;
        n_steps = 0;
        send_idle_pct = 20;
        recv_idle_pct = 55;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_mazes(650);
        send_idle_pct = 55;
        recv_idle_pct = 20;
        test_random_mazes(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mazes(650);

        drain();
        $display("covered %0d maze starts and %0d steps", n_starts, n_steps);
        $display("carved %0d edges, saw %0d finished or empty-stack results", n_edges, n_done);
        if (n_errors == 0) begin
            $display("maze_dfs_carver_top_test OK");
        end else begin
            $display("maze_dfs_carver_top_test NOT OK");
        end
        $finish;
    end
endmodule

// File: maze_dfs_carver_top.f
+incdir+hw/rtl
hw/rtl/mdc_pkg.sv
hw/rtl/mdc_divider.sv
hw/rtl/mdc_datapath.sv
hw/rtl/mdc_ctrl.sv
hw/rtl/maze_dfs_carver_top.sv
hw/rtl/mdc_checker.sv
test/maze_dfs_carver_top_test.sv
